/* sv/binary_heap_priority_queue_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the binary heap priority queue
// ---------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define HPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hpq_pkg.sv */
// ---------------------------------------------------------------------------
// hpq_pkg
// Types, codes and the ordering compare shared by the heap queue modules.
// ---------------------------------------------------------------------------
`default_nettype none

package hpq_pkg;

  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 9;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic REG_LARGEST_FIRST = 1'b0;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_CMP,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_POP_LEFT,
    ST_POP_RIGHT,
    ST_PLACE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    key_t   key;
    value_t value;
  } entry_t;

  typedef struct packed {
    logic   mode;
    key_t   key;
    value_t value;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    key_t                  out_key;
    value_t                out_value;
    logic [COUNT_BITS-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ctrl_stat_t;

  // true when key a sits strictly above key b
  function automatic logic ranks_above(input key_t a, input key_t b, input logic largest);
    ranks_above = largest ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

/* sv/binary_heap_priority_queue.sv */
// Push: sift-up compares the new entry with its parent one level at a time.
// Pop: sift-down reads the left and then any right child per level; both share one read port.
// One transaction at a time; the next is taken once the result is in the output register.
// Full or empty rejections go straight to the report state without touching the entry store.
// Reset clears the entry count, ordering and handshake state; the entry store is not cleared.
// ---------------------------------------------------------------------------
// binary_heap_priority_queue
// Fixed-depth binary heap priority queue with key and payload per entry.
// ---------------------------------------------------------------------------
`default_nettype none

`include "binary_heap_priority_queue_assert.svh"

module binary_heap_priority_queue #(
  parameter int DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire hpq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output hpq_pkg::rsp_t      rsp
);
  import hpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW+8:0] DEPTH_EXT = (CW+9)'(DEPTH);

  logic          largest_first;
  ctrl_stat_t    stat;
  rsp_t          result;
  logic          rsp_free;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  logic          rsp_full;
  logic          rsp_empty;
  logic          rsp_clear;
  logic          req_accept;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      largest_first <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_LARGEST_FIRST) begin
      largest_first <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_LARGEST_FIRST) ? {31'd0, largest_first} : '0;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = stat.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stat.done && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && rsp_free) begin
      rsp <= result;
    end
  end

  hpq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .largest_first (largest_first),
    .req_valid     (req_valid),
    .req           (req),
    .rsp_free      (rsp_free),
    .stat          (stat),
    .result        (result),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_data       (rd_data)
  );

  hpq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign rsp_full   = rsp_valid && rsp.status == STATUS_FULL;
  assign rsp_empty  = rsp_valid && rsp.status == STATUS_EMPTY;
  assign rsp_clear  = rsp.count == '0 && rsp.out_key == '0 && rsp.out_value == '0;
  assign req_accept = req_valid && !req_stall;

  `HPQ_ASSERT_IMP(a_full_count, clk, rst, rsp_full, rsp.count == DEPTH_EXT[8:0], "bad full count")
  `HPQ_ASSERT_IMP(a_empty_result, clk, rst, rsp_empty, rsp_clear, "bad empty result")
  `HPQ_ASSERT_NXT(a_busy_after_accept, clk, rst, req_accept, req_stall, "not busy after accept")

endmodule

`default_nettype wire

/* sv/hpq_ram.sv */
// ---------------------------------------------------------------------------
// hpq_ram
// Heap entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hpq_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire hpq_pkg::entry_t wr_data,
  output hpq_pkg::entry_t      rd_data
);
  import hpq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/hpq_ctrl.sv */
// ---------------------------------------------------------------------------
// hpq_ctrl
// Sequencer for sift-up on push and sift-down on pop over the entry store.
// ---------------------------------------------------------------------------
`default_nettype none

module hpq_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int CW    = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             largest_first,
  input  wire logic             req_valid,
  input  wire hpq_pkg::req_t    req,
  input  wire logic             rsp_free,
  output hpq_pkg::ctrl_stat_t   stat,
  output hpq_pkg::rsp_t         result,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output hpq_pkg::entry_t       wr_data,
  input  wire hpq_pkg::entry_t  rd_data
);
  import hpq_pkg::*;

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    parent_of = (p - 1'b1) >> 1;
  endfunction

  function automatic logic has_child(input logic [AW:0] c, input logic [CW-1:0] n);
    logic [AW+1:0] ce;
    logic [AW+1:0] ne;
    ce = (AW+2)'(c);
    ne = (AW+2)'(n);
    has_child = ce < ne;
  endfunction

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  logic [AW-1:0] cidx, cidx_next;
  entry_t        hold, hold_next;
  entry_t        lchild, lchild_next;
  status_t       res_status, res_status_next;
  key_t          res_key, res_key_next;
  value_t        res_value, res_value_next;

  logic          pick_right;
  entry_t        dec_entry;
  logic [AW-1:0] dec_idx;
  logic [AW:0]   rc;
  logic [AW:0]   lc_new;
  logic [CW+8:0] count_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    cidx       <= cidx_next;
    hold       <= hold_next;
    lchild     <= lchild_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_value  <= res_value_next;
  end

  assign rc         = {1'b0, cidx} + 1'b1;
  assign pick_right = (state == ST_POP_RIGHT) && ranks_above(rd_data.key, lchild.key, largest_first);
  assign dec_entry  = (state == ST_POP_RIGHT && !pick_right) ? lchild : rd_data;
  assign dec_idx    = pick_right ? rc[AW-1:0] : cidx;
  assign lc_new     = {dec_idx, 1'b1};

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    cidx_next       = cidx;
    hold_next       = hold;
    lchild_next     = lchild;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_value_next  = res_value;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = hold;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          res_key_next    = '0;
          res_value_next  = '0;
          res_status_next = STATUS_OK;
          if (req.mode == MODE_PUSH) begin
            if (count == FULL_COUNT) begin
              res_status_next = STATUS_FULL;
              state_next      = ST_REPORT;
            end else begin
              hold_next  = '{key: req.key, value: req.value};
              count_next = count + 1'b1;
              pos_next   = count[AW-1:0];
              if (count == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{key: req.key, value: req.value};
                state_next = ST_REPORT;
              end else begin
                cidx_next  = parent_of(count[AW-1:0]);
                rd_en      = 1'b1;
                rd_addr    = parent_of(count[AW-1:0]);
                state_next = ST_PUSH_CMP;
              end
            end
          end else begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
              state_next      = ST_REPORT;
            end else begin
              count_next = count - 1'b1;
              pos_next   = '0;
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_next = ST_POP_ROOT;
            end
          end
        end
      end

      ST_PUSH_CMP: begin
        wr_en = 1'b1;
        if (ranks_above(hold.key, rd_data.key, largest_first)) begin
          wr_data  = rd_data;
          pos_next = cidx;
          if (cidx == '0) begin
            state_next = ST_PLACE;
          end else begin
            cidx_next = parent_of(cidx);
            rd_en     = 1'b1;
            rd_addr   = parent_of(cidx);
          end
        end else begin
          state_next = ST_REPORT;
        end
      end

      ST_POP_ROOT: begin
        res_key_next   = rd_data.key;
        res_value_next = rd_data.value;
        rd_en          = 1'b1;
        rd_addr        = count[AW-1:0];
        state_next     = ST_POP_LAST;
      end

      ST_POP_LAST: begin
        hold_next = rd_data;
        if (has_child({pos, 1'b1}, count)) begin
          cidx_next  = {pos[AW-2:0], 1'b1};
          rd_en      = 1'b1;
          rd_addr    = {pos[AW-2:0], 1'b1};
          state_next = ST_POP_LEFT;
        end else begin
          wr_en      = (count != '0);
          wr_data    = rd_data;
          state_next = ST_REPORT;
        end
      end

      ST_POP_LEFT,
      ST_POP_RIGHT: begin
        if (state == ST_POP_LEFT) begin
          lchild_next = rd_data;
        end
        if (state == ST_POP_LEFT && has_child(rc, count)) begin
          rd_en      = 1'b1;
          rd_addr    = rc[AW-1:0];
          state_next = ST_POP_RIGHT;
        end else begin
          wr_en = 1'b1;
          if (ranks_above(dec_entry.key, hold.key, largest_first)) begin
            wr_data  = dec_entry;
            pos_next = dec_idx;
            if (has_child(lc_new, count)) begin
              cidx_next  = lc_new[AW-1:0];
              rd_en      = 1'b1;
              rd_addr    = lc_new[AW-1:0];
              state_next = ST_POP_LEFT;
            end else begin
              state_next = ST_PLACE;
            end
          end else begin
            state_next = ST_REPORT;
          end
        end
      end

      ST_PLACE: begin
        wr_en      = 1'b1;
        state_next = ST_REPORT;
      end

      ST_REPORT: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign count_ext = {9'd0, count};

  assign stat.busy = (state != ST_IDLE);
  assign stat.done = (state == ST_REPORT);

  assign result.status    = res_status;
  assign result.out_key   = res_key;
  assign result.out_value = res_value;
  assign result.count     = count_ext[COUNT_BITS-1:0];

endmodule

`default_nettype wire

/* tb/sv/binary_heap_priority_queue_test.sv */
// ---------------------------------------------------------------------------
// binary_heap_priority_queue_test
// Drives push and pop transactions into the heap queue with random gaps and
// output stalls, predicts every result with an independent heap held in the
// bench, and compares each result field by field.  Covers empty and full
// rejections, equal keys, extreme keys and both orderings, including a
// change of ordering while entries are held.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue_test;
  import hpq_pkg::*;

  localparam int HEAP_DEPTH = 256;
  localparam int POP_LATENCY = 2 * 8 + 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [2:0] ADDR_LARGEST_FIRST = {REG_LARGEST_FIRST, 2'b00};
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  key_t heap_keys[HEAP_DEPTH];
  value_t heap_values[HEAP_DEPTH];
  int held_entries;
  logic largest_first_model;
  rsp_t awaited_rsps[$];
  int error_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;

  binary_heap_priority_queue #(
    .DEPTH(HEAP_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic bit precedes(key_t a, key_t b);
    return largest_first_model ? (a > b) : (a < b);
  endfunction

  function automatic rsp_t apply_heap_op(req_t item);
    rsp_t res;
    int pos;
    int up;
    int c;
    int n;
    bit moving;
    key_t last_key;
    value_t last_value;
    res = '0;
    res.status = STATUS_OK;
    if (item.mode == MODE_PUSH) begin
      if (held_entries >= HEAP_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        pos = held_entries;
        moving = 1'b1;
        while (moving && pos > 0) begin
          up = (pos - 1) / 2;
          if (precedes(item.key, heap_keys[up])) begin
            heap_keys[pos] = heap_keys[up];
            heap_values[pos] = heap_values[up];
            pos = up;
          end else begin
            moving = 1'b0;
          end
        end
        heap_keys[pos] = item.key;
        heap_values[pos] = item.value;
        held_entries++;
      end
    end else if (held_entries == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.out_key = heap_keys[0];
      res.out_value = heap_values[0];
      n = held_entries - 1;
      last_key = heap_keys[n];
      last_value = heap_values[n];
      pos = 0;
      moving = 1'b1;
      while (moving && 2 * pos + 1 < n) begin
        c = 2 * pos + 1;
        if (c + 1 < n && precedes(heap_keys[c + 1], heap_keys[c])) c++;
        if (precedes(heap_keys[c], last_key)) begin
          heap_keys[pos] = heap_keys[c];
          heap_values[pos] = heap_values[c];
          pos = c;
        end else begin
          moving = 1'b0;
        end
      end
      if (n > 0) begin
        heap_keys[pos] = last_key;
        heap_values[pos] = last_value;
      end
      held_entries = n;
    end
    res.count = held_entries[COUNT_BITS-1:0];
    return res;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic send_op(input logic mode, input key_t key, input value_t value);
    req_t item;
    int gap;
    item.mode = mode;
    item.key = key;
    item.value = value;
    gap = idle_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    awaited_rsps.push_back(apply_heap_op(item));
  endtask

  task automatic push_op(input key_t key, input value_t value);
    send_op(MODE_PUSH, key, value);
  endtask

  task automatic pop_op();
    send_op(MODE_POP, $urandom, $urandom);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (awaited_rsps.size() != 0) @(posedge clk);
    repeat (POP_LATENCY) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_LARGEST_FIRST) largest_first_model = data[0];
    @(posedge clk);
  endtask

  task automatic set_order(input logic largest);
    settle();
    apb_write(ADDR_LARGEST_FIRST, {31'($urandom_range(0, 32'h7fffffff)), largest});
  endtask

  task automatic apb_read_check(input logic [2:0] addr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'b0, largest_first_model})
      flag_error($sformatf("register read: expected %h, got %h",
                           {31'b0, largest_first_model}, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic key_t draw_key(input bit narrow);
    key_t k;
    if (narrow) begin
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) k = ~k;
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      rsp_stall <= 1'b1;
      stall_left <= idle_gap();
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsps.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d key %h value %h count %0d",
                             rsp.status, rsp.out_key, rsp.out_value, rsp.count));
      end else begin
        exp_rsp = awaited_rsps.pop_front();
        if (rsp.status !== exp_rsp.status || rsp.out_key !== exp_rsp.out_key ||
            rsp.out_value !== exp_rsp.out_value || rsp.count !== exp_rsp.count)
          flag_error($sformatf({"result mismatch: expected status %0d key %h value %h ",
                                "count %0d, got status %0d key %h value %h count %0d"},
                               exp_rsp.status, exp_rsp.out_key, exp_rsp.out_value,
                               exp_rsp.count, rsp.status, rsp.out_key, rsp.out_value,
                               rsp.count));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic test_directed();
    pop_op();
    push_op(32'hffffffff, 32'hffffffff);
    push_op(32'h0, 32'h0);
    push_op(32'h7, 32'ha);
    push_op(32'h7, 32'hb);
    push_op(32'h7, 32'hc);
    push_op(32'haaaaaaaa, 32'h55555555);
    push_op(32'h55555555, 32'haaaaaaaa);
    repeat (7) pop_op();
    pop_op();
    set_order(1'b1);
    push_op(32'h0, 32'h1);
    push_op(32'hffffffff, 32'h2);
    push_op(32'h80000000, 32'h3);
    push_op(32'hffffffff, 32'h4);
    repeat (4) pop_op();
    pop_op();
  endtask

  task automatic test_register_access();
    settle();
    apb_read_check(ADDR_LARGEST_FIRST);
    apb_write(ADDR_UNUSED, {31'h7fffffff, ~largest_first_model});
    apb_read_check(ADDR_LARGEST_FIRST);
    apb_write(ADDR_LARGEST_FIRST, 32'h0);
    apb_read_check(ADDR_LARGEST_FIRST);
    apb_write(ADDR_LARGEST_FIRST, 32'hffffffff);
    apb_read_check(ADDR_LARGEST_FIRST);
  endtask

  task automatic test_fill_and_drain();
    set_order(1'b1);
    repeat (HEAP_DEPTH + 3) push_op(draw_key($urandom_range(0, 4) == 0), $urandom);
    repeat (HEAP_DEPTH + 2) pop_op();
  endtask

  task automatic test_random_mix(input logic largest, input int n_items,
                                 input int push_pct, input bit narrow, input bit quiet);
    set_order(largest);
    no_idle = quiet;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < push_pct) push_op(draw_key(narrow), $urandom);
      else pop_op();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    req = '0;
    held_entries = 0;
    largest_first_model = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_access();
    test_fill_and_drain();
    test_random_mix(1'b0, 200, 60, 1'b0, 1'b0);
    test_random_mix(1'b1, 200, 50, 1'b1, 1'b1);
    test_random_mix(1'b0, 200, 75, 1'b1, 1'b0);
    test_random_mix(1'b1, 200, 35, 1'b0, 1'b0);
    settle();
    if (awaited_rsps.size() != 0) flag_error("results still outstanding at end of run");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
